// ===== design/assert_macros.svh =====
// assertion helpers used by the relay sequencer design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// Operation codes, channel mode codes and fixed widths of the relay sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcs_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET_ONE = 3'd1,
    OP_SET_ALL = 3'd2,
    OP_TIMER   = 3'd3,
    OP_PULSE   = 3'd4,
    OP_BLINK   = 3'd5,
    OP_QUERY   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_TOGGLE = 2'd0,
    MODE_TIMER  = 2'd1,
    MODE_PULSE  = 2'd2,
    MODE_BLINK  = 2'd3
  } mode_t;

  localparam int TIME_W   = 32;
  localparam int SECS_W   = 23;
  localparam int CHAN_W   = 3;
  localparam int MASK_W   = 8;
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

endpackage

// ===== design/relay_channel_sequencer.sv =====
// ----------------------------------------------------------------------------
// relay_channel_sequencer
// Multi-channel relay sequencer with set, timer, pulse, blink, tick and query.
// ----------------------------------------------------------------------------
// path: the input register, then the result register, which loads when the output does not stall
// throughput: one item per cycle while the output does not stall, limited by the single update stage
// that reads and writes the channel state in the same cycle
// reset: synchronous, active low; clears pipeline valids and every channel
// to toggle mode, inactive, de-energized
`timescale 1ns / 1ps
`include "assert_macros.svh"

module relay_channel_sequencer #(
  parameter int CHANNELS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_operation,
  input  logic [rcs_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [rcs_pkg::CHAN_W-1:0]   in_channel,
  input  logic                         in_level,
  input  logic [rcs_pkg::SECS_W-1:0]   in_timer_seconds,
  input  logic [rcs_pkg::TIME_W-1:0]   in_pulse_ms,
  input  logic [rcs_pkg::TIME_W-1:0]   in_on_time_ms,
  input  logic [rcs_pkg::TIME_W-1:0]   in_off_time_ms,
  input  logic [rcs_pkg::TIME_W-1:0]   in_repeat_count,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rcs_pkg::MASK_W-1:0]   out_relay_levels,
  output logic [rcs_pkg::MASK_W-1:0]   out_changed_mask,
  output logic [rcs_pkg::MASK_W-1:0]   out_finished_mask,
  output logic                         out_status_active,
  output logic [1:0]                   out_status_mode,
  output logic                         out_status_blink_on,
  output logic [rcs_pkg::TIME_W-1:0]   out_status_count,
  output logic [rcs_pkg::TIME_W-1:0]   out_status_remaining_ms
);

  import rcs_pkg::*;

  // only channels 0 to 7 show up in the masks
  localparam int VIS_CH = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_r, out_valid_r;
  logic adv;     // result register can take a new value
  logic fire;    // item in the input register is processed this cycle

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // --------------------------------------------------------------------------
  // input register; timer length is scaled and saturated ahead of it
  // --------------------------------------------------------------------------
  logic [TIME_W:0]    timer_prod;
  logic [TIME_W-1:0]  timer_ms;

  assign timer_prod = (TIME_W + 1)'(in_timer_seconds) * (TIME_W + 1)'(MS_PER_SECOND);
  assign timer_ms   = timer_prod[TIME_W] ? '1 : timer_prod[TIME_W-1:0];

  op_t                s1_op_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [CHAN_W-1:0]  s1_channel_r;
  logic               s1_level_r;
  logic [TIME_W-1:0]  s1_timer_ms_r;
  logic [TIME_W-1:0]  s1_pulse_r;
  logic [TIME_W-1:0]  s1_on_r;
  logic [TIME_W-1:0]  s1_off_r;
  logic [TIME_W-1:0]  s1_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    // payload loads on every transfer, holds while stalled
    if (!in_stall && in_valid) begin
      s1_op_r       <= op_t'(in_operation);
      s1_now_r      <= in_now_ms;
      s1_channel_r  <= in_channel;
      s1_level_r    <= in_level;
      s1_timer_ms_r <= timer_ms;
      s1_pulse_r    <= in_pulse_ms;
      s1_on_r       <= in_on_time_ms;
      s1_off_r      <= in_off_time_ms;
      s1_count_r    <= in_repeat_count;
    end
  end

  // --------------------------------------------------------------------------
  // channel state
  // --------------------------------------------------------------------------
  mode_t              mode_r   [CHANNELS];
  logic [CHANNELS-1:0] active_r, level_r, phase_r;
  logic [TIME_W-1:0]  start_r  [CHANNELS];
  logic [TIME_W-1:0]  dur_r    [CHANNELS];
  logic [TIME_W-1:0]  on_r     [CHANNELS];
  logic [TIME_W-1:0]  off_r    [CHANNELS];
  logic [TIME_W-1:0]  count_r  [CHANNELS];

  mode_t              mode_nxt [CHANNELS];
  logic [CHANNELS-1:0] active_nxt, level_nxt, phase_nxt, done_nxt;
  logic [TIME_W-1:0]  start_nxt [CHANNELS];
  logic [TIME_W-1:0]  dur_nxt   [CHANNELS];
  logic [TIME_W-1:0]  on_nxt    [CHANNELS];
  logic [TIME_W-1:0]  off_nxt   [CHANNELS];
  logic [TIME_W-1:0]  count_nxt [CHANNELS];

  logic [TIME_W-1:0]  elapsed_w [CHANNELS];
  logic [CHANNELS-1:0] expired_w, toggle_w;

  // per-channel elapsed time and the one threshold that matters for its mode
  always_comb begin
    logic [TIME_W-1:0] thr;
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed_w[i] = s1_now_r - start_r[i];
      if (mode_r[i] == MODE_BLINK) begin
        thr = phase_r[i] ? on_r[i] : off_r[i];
      end else begin
        thr = dur_r[i];
      end
      expired_w[i] = (elapsed_w[i] >= thr);
      toggle_w[i]  = (mode_r[i] == MODE_TOGGLE);
    end
  end

  // next state of every channel
  always_comb begin
    logic sel;
    for (int i = 0; i < CHANNELS; i++) begin
      sel          = (int'(s1_channel_r) == i);
      mode_nxt[i]  = mode_r[i];
      active_nxt[i] = active_r[i];
      level_nxt[i] = level_r[i];
      phase_nxt[i] = phase_r[i];
      done_nxt[i]  = 1'b0;
      start_nxt[i] = start_r[i];
      dur_nxt[i]   = dur_r[i];
      on_nxt[i]    = on_r[i];
      off_nxt[i]   = off_r[i];
      count_nxt[i] = count_r[i];

      unique case (s1_op_r)
        OP_TICK: begin
          if (active_r[i] && expired_w[i]) begin
            case (mode_r[i])
              MODE_TIMER, MODE_PULSE: begin
                level_nxt[i]  = 1'b0;
                active_nxt[i] = 1'b0;
                mode_nxt[i]   = MODE_TOGGLE;
                done_nxt[i]   = 1'b1;
              end
              MODE_BLINK: begin
                if (phase_r[i]) begin
                  // end of on phase
                  level_nxt[i] = 1'b0;
                  phase_nxt[i] = 1'b0;
                  start_nxt[i] = s1_now_r;
                end else if (count_r[i] == TIME_W'(1)) begin
                  // last cycle done, stays de-energized
                  count_nxt[i]  = '0;
                  active_nxt[i] = 1'b0;
                  mode_nxt[i]   = MODE_TOGGLE;
                  done_nxt[i]   = 1'b1;
                end else begin
                  // zero count blinks forever
                  if (count_r[i] != '0) begin
                    count_nxt[i] = count_r[i] - TIME_W'(1);
                  end
                  level_nxt[i] = 1'b1;
                  phase_nxt[i] = 1'b1;
                  start_nxt[i] = s1_now_r;
                end
              end
              default: ;
            endcase
          end
        end
        OP_SET_ONE: begin
          if (sel) begin
            active_nxt[i] = 1'b0;
            mode_nxt[i]   = MODE_TOGGLE;
            level_nxt[i]  = s1_level_r;
          end
        end
        OP_SET_ALL: begin
          active_nxt[i] = 1'b0;
          mode_nxt[i]   = MODE_TOGGLE;
          level_nxt[i]  = s1_level_r;
        end
        OP_TIMER, OP_PULSE: begin
          if (sel) begin
            mode_nxt[i]   = (s1_op_r == OP_TIMER) ? MODE_TIMER : MODE_PULSE;
            active_nxt[i] = 1'b1;
            level_nxt[i]  = 1'b1;
            start_nxt[i]  = s1_now_r;
            dur_nxt[i]    = (s1_op_r == OP_TIMER) ? s1_timer_ms_r : s1_pulse_r;
          end
        end
        OP_BLINK: begin
          if (sel) begin
            mode_nxt[i]   = MODE_BLINK;
            active_nxt[i] = 1'b1;
            level_nxt[i]  = 1'b1;
            phase_nxt[i]  = 1'b1;
            start_nxt[i]  = s1_now_r;
            on_nxt[i]     = s1_on_r;
            off_nxt[i]    = s1_off_r;
            count_nxt[i]  = s1_count_r;
          end
        end
        default: ;  // query and the unused code leave state alone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      level_r  <= '0;
      phase_r  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        mode_r[i] <= MODE_TOGGLE;
      end
    end else if (fire) begin
      active_r <= active_nxt;
      level_r  <= level_nxt;
      phase_r  <= phase_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        mode_r[i] <= mode_nxt[i];
      end
    end
    // timing payload is only read while a channel is active
    if (fire) begin
      for (int i = 0; i < CHANNELS; i++) begin
        start_r[i] <= start_nxt[i];
        dur_r[i]   <= dur_nxt[i];
        on_r[i]    <= on_nxt[i];
        off_r[i]   <= off_nxt[i];
        count_r[i] <= count_nxt[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // query status, taken from the state before this item
  // --------------------------------------------------------------------------
  logic               st_active, st_phase;
  mode_t              st_mode;
  logic [TIME_W-1:0]  st_count, st_rem;

  always_comb begin
    logic               q_hit, q_active, q_phase;
    mode_t              q_mode;
    logic [TIME_W-1:0]  q_count, q_el, q_dur;
    logic [TIME_W:0]    q_diff;
    q_hit    = 1'b0;
    q_active = 1'b0;
    q_phase  = 1'b0;
    q_mode   = MODE_TOGGLE;
    q_count  = '0;
    q_el     = '0;
    q_dur    = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(s1_channel_r) == i) begin
        q_hit    = 1'b1;
        q_active = active_r[i];
        q_phase  = phase_r[i];
        q_mode   = mode_r[i];
        q_count  = count_r[i];
        q_el     = elapsed_w[i];
        q_dur    = dur_r[i];
      end
    end
    // borrow out means the duration has passed
    q_diff = {1'b0, q_dur} - {1'b0, q_el};

    st_active = 1'b0;
    st_mode   = MODE_TOGGLE;
    st_phase  = 1'b0;
    st_count  = '0;
    st_rem    = '0;
    if (s1_op_r == OP_QUERY && q_hit) begin
      st_active = q_active;
      st_mode   = q_mode;
      if (q_active && q_mode == MODE_BLINK) begin
        st_phase = q_phase;
        st_count = q_count;
      end else if (q_active && (q_mode == MODE_TIMER || q_mode == MODE_PULSE)) begin
        st_rem = q_diff[TIME_W] ? '0 : q_diff[TIME_W-1:0];
      end
    end
  end

  // visible slice of the level and finished vectors
  logic [MASK_W-1:0] lv_before, lv_after, done_vis;

  always_comb begin
    lv_before = '0;
    lv_after  = '0;
    done_vis  = '0;
    for (int i = 0; i < VIS_CH; i++) begin
      lv_before[i] = level_r[i];
      lv_after[i]  = level_nxt[i];
      done_vis[i]  = done_nxt[i];
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [MASK_W-1:0]  out_relay_levels_r, out_changed_mask_r, out_finished_mask_r;
  logic               out_status_active_r, out_status_blink_on_r;
  logic [1:0]         out_status_mode_r;
  logic [TIME_W-1:0]  out_status_count_r, out_status_remaining_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (fire) begin
      out_relay_levels_r        <= lv_after;
      out_changed_mask_r        <= lv_before ^ lv_after;
      out_finished_mask_r       <= done_vis;
      out_status_active_r       <= st_active;
      out_status_mode_r         <= st_mode;
      out_status_blink_on_r     <= st_phase;
      out_status_count_r        <= st_count;
      out_status_remaining_ms_r <= st_rem;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_relay_levels        = out_relay_levels_r;
  assign out_changed_mask        = out_changed_mask_r;
  assign out_finished_mask       = out_finished_mask_r;
  assign out_status_active       = out_status_active_r;
  assign out_status_mode         = out_status_mode_r;
  assign out_status_blink_on     = out_status_blink_on_r;
  assign out_status_count        = out_status_count_r;
  assign out_status_remaining_ms = out_status_remaining_ms_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_stall_needs_item, in_stall |-> s1_valid_r, "stall with empty input register")
  `ASSERT_CLK(a_active_not_toggle, (active_r & toggle_w) == '0, "active channel in toggle mode")
  `ASSERT_CLK(a_done_only_tick, (fire && s1_op_r != OP_TICK) |=> out_finished_mask == '0, "finished event outside tick")
  `ASSERT_CLK(a_status_only_query, (fire && s1_op_r != OP_QUERY) |=> (!out_status_active && out_status_remaining_ms == '0), "status outside query")

endmodule
